// File: rtl/literal_find_and_replace_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for literal find-and-replace
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LITERAL_FIND_AND_REPLACE_ASSERT_SVH
`define LITERAL_FIND_AND_REPLACE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LFR_ASSERT(lbl, prop, msg)
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Types and constants shared by the find-and-replace front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

	localparam int UNIT_W      = 16;
	localparam int CFG_W       = 64;
	localparam int LEN_W       = 3;
	localparam int IDX_W       = 3;
	localparam int PATTERN_MAX = 4;
	localparam int SLOTS       = 4;
	localparam int WIN_DEPTH   = (PATTERN_MAX < SLOTS) ? PATTERN_MAX : SLOTS;
	localparam int POS_W       = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Saturation limits for the length registers.
	localparam logic [LEN_W-1:0] SEARCH_CAP  = LEN_W'(WIN_DEPTH);
	localparam logic [LEN_W-1:0] REPLACE_CAP = LEN_W'(SLOTS);

	typedef enum logic [IDX_W-1:0] {
		CFG_SEARCH_UNITS  = 3'd0,
		CFG_SEARCH_LEN    = 3'd1,
		CFG_REPLACE_UNITS = 3'd2,
		CFG_REPLACE_LEN   = 3'd3,
		CFG_REPLACE_ALL   = 3'd4
	} lfr_cfg_idx_t;

	// One command: an optional replacement, then a run of units, then an optional replacement.
	typedef struct packed {
		logic [WIN_DEPTH-1:0][UNIT_W-1:0] units;
		logic [LEN_W-1:0]                 n_units;
		logic                             rep_first;
		logic                             rep_after;
		logic                             last;
	} lfr_cmd_t;

	typedef struct packed {
		logic [SLOTS-1:0][UNIT_W-1:0] units;
		logic [LEN_W-1:0]             len;
	} lfr_repl_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_REP1,
		PH_UNITS,
		PH_REP2,
		PH_EMPTY
	} lfr_phase_t;

endpackage

`default_nettype wire

// File: rtl/lfr_front.sv
// ----------------------------------------------------------------------------
// lfr_front
// Holds configuration and the look-ahead window, classifies each input word
// and turns it into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [lfr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [lfr_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        item_valid,
	input  wire logic [lfr_pkg::UNIT_W-1:0]  src_unit,
	input  wire logic                        unit_valid,
	input  wire logic                        end_of_string,
	input  wire logic                        q_full,
	output logic                             q_push,
	output lfr_pkg::lfr_cmd_t                q_cmd,
	output lfr_pkg::lfr_repl_t               repl
);
	import lfr_pkg::*;

	logic [CFG_W-1:0]  search_units_q;
	logic [LEN_W-1:0]  search_len_q;
	logic [CFG_W-1:0]  replace_units_q;
	logic [LEN_W-1:0]  replace_len_q;
	logic              replace_all_q;

	logic [WIN_DEPTH-1:0][UNIT_W-1:0] win_q;
	logic [LEN_W-1:0]                 cnt_q;
	logic                             once_q;

	logic [LEN_W-1:0]                 slen;
	logic                             active;
	logic                             append;
	logic [WIN_DEPTH-1:0][UNIT_W-1:0] wn;
	logic [WIN_DEPTH-1:0][UNIT_W-1:0] wn_shift;
	logic [LEN_W-1:0]                 cnt_app;
	logic                             full;
	logic                             eq;
	logic                             rep_first;
	logic                             once_next;
	logic [LEN_W-1:0]                 n_units;
	logic                             produce;
	logic                             accept;

	assign slen   = (search_len_q > SEARCH_CAP) ? SEARCH_CAP : search_len_q;
	assign active = replace_all_q || !once_q;
	assign append = unit_valid && (slen != '0);

	assign repl.units = replace_units_q;
	assign repl.len   = (replace_len_q > REPLACE_CAP) ? REPLACE_CAP : replace_len_q;

	always_comb begin
		wn = win_q;
		if (append) begin
			wn[cnt_q[POS_W-1:0]] = src_unit;
		end
		wn_shift = wn;
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			wn_shift[i] = wn[i+1];
		end
	end

	assign cnt_app = cnt_q + {{(LEN_W-1){1'b0}}, append};
	assign full    = append && (cnt_app == slen);

	// The full window is compared against the pattern up to its length.
	always_comb begin
		eq = active;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if ((LEN_W'(i) < slen) && (wn[i] != search_units_q[i*UNIT_W +: UNIT_W])) begin
				eq = 1'b0;
			end
		end
	end

	assign rep_first = unit_valid && (((slen == '0) && active) || (full && eq));
	assign once_next = once_q || rep_first;

	always_comb begin
		if (slen == '0) begin
			n_units = unit_valid ? LEN_W'(1) : '0;
		end else if (full && eq) begin
			n_units = '0;
		end else if (full) begin
			n_units = end_of_string ? slen : LEN_W'(1);
		end else begin
			n_units = end_of_string ? cnt_app : '0;
		end
	end

	always_comb begin
		q_cmd.units = wn;
		if (slen == '0) begin
			q_cmd.units[0] = src_unit;
		end
		q_cmd.n_units   = n_units;
		q_cmd.rep_first = rep_first;
		q_cmd.rep_after = end_of_string && (slen == '0) && (replace_all_q || !once_next);
		q_cmd.last      = end_of_string;
	end

	// A word that only fills the window produces nothing downstream.
	assign produce = end_of_string || (n_units != '0) || (rep_first && (repl.len != '0));
	assign accept  = item_valid && !q_full;
	assign q_push  = accept && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_units_q  <= '0;
			search_len_q    <= '0;
			replace_units_q <= '0;
			replace_len_q   <= '0;
			replace_all_q   <= 1'b0;
			cnt_q           <= '0;
			once_q          <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SEARCH_UNITS: begin
					search_units_q <= cfg_data;
					cnt_q          <= '0;
				end
				CFG_SEARCH_LEN: begin
					search_len_q <= cfg_data[LEN_W-1:0];
					cnt_q        <= '0;
				end
				CFG_REPLACE_UNITS: begin
					replace_units_q <= cfg_data;
				end
				CFG_REPLACE_LEN: begin
					replace_len_q <= cfg_data[LEN_W-1:0];
				end
				CFG_REPLACE_ALL: begin
					replace_all_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (end_of_string) begin
				cnt_q  <= '0;
				once_q <= 1'b0;
			end else begin
				if (full) begin
					cnt_q <= eq ? '0 : (slen - LEN_W'(1));
				end else begin
					cnt_q <= cnt_app;
				end
				once_q <= once_next;
			end
		end
	end

	// Window contents carry no reset; only cnt_q says which entries are live.
	always_ff @(posedge clk) begin
		if (accept && !cfg_wr_en) begin
			win_q <= (full && !eq) ? wn_shift : wn;
		end
	end

endmodule

`default_nettype wire

// File: rtl/lfr_cmd_queue.sv
// ----------------------------------------------------------------------------
// lfr_cmd_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_cmd_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire lfr_pkg::lfr_cmd_t push_cmd,
	input  wire logic         pop,
	output lfr_pkg::lfr_cmd_t head_cmd,
	output logic              full,
	output logic              avail
);
	import lfr_pkg::*;

	lfr_cmd_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign head_cmd = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// File: rtl/lfr_back.sv
// ----------------------------------------------------------------------------
// lfr_back
// Walks each command one result word per cycle into the output register while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "literal_find_and_replace_assert.svh"

module lfr_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lfr_pkg::lfr_cmd_t           q_cmd,
	input  wire logic                        q_avail,
	input  wire lfr_pkg::lfr_repl_t          repl,
	input  wire logic                        result_stall,
	output logic                             q_pop,
	output logic                             result_valid,
	output logic [lfr_pkg::UNIT_W-1:0]       out_unit,
	output logic                             out_valid,
	output logic                             out_last
);
	import lfr_pkg::*;

	lfr_phase_t        phase_q;
	lfr_phase_t        phase_d;
	lfr_phase_t        step_phase;
	logic [POS_W-1:0]  idx_q;
	logic [POS_W-1:0]  idx_d;
	logic [POS_W-1:0]  step_idx;
	lfr_cmd_t          cur_q;
	logic              emit_en;
	logic              done;
	logic [UNIT_W-1:0] res_unit;
	logic              res_real;
	logic              rep_end;
	logic              units_end;
	logic              has_after;

	logic              result_valid_q;
	logic [UNIT_W-1:0] out_unit_q;
	logic              out_valid_q;
	logic              out_last_q;

	function automatic lfr_phase_t first_phase(input lfr_cmd_t c, input logic [LEN_W-1:0] len);
		lfr_phase_t ph;
		if (c.rep_first && (len != '0)) begin
			ph = PH_REP1;
		end else if (c.n_units != '0) begin
			ph = PH_UNITS;
		end else if (c.rep_after && (len != '0)) begin
			ph = PH_REP2;
		end else begin
			ph = PH_EMPTY;
		end
		return ph;
	endfunction

	assign emit_en   = (phase_q != PH_IDLE) && (!result_valid_q || !result_stall);
	assign rep_end   = ({1'b0, idx_q} == (repl.len - LEN_W'(1)));
	assign units_end = ({1'b0, idx_q} == (cur_q.n_units - LEN_W'(1)));
	assign has_after = cur_q.rep_after && (repl.len != '0);

	always_comb begin
		res_unit   = '0;
		res_real   = 1'b0;
		done       = 1'b0;
		step_phase = phase_q;
		step_idx   = idx_q + POS_W'(1);
		case (phase_q)
			PH_REP1: begin
				res_unit = repl.units[idx_q];
				res_real = 1'b1;
				if (rep_end) begin
					step_idx = '0;
					if (cur_q.n_units != '0) begin
						step_phase = PH_UNITS;
					end else if (has_after) begin
						step_phase = PH_REP2;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_UNITS: begin
				res_unit = cur_q.units[idx_q];
				res_real = 1'b1;
				if (units_end) begin
					step_idx = '0;
					if (has_after) begin
						step_phase = PH_REP2;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_REP2: begin
				res_unit = repl.units[idx_q];
				res_real = 1'b1;
				done     = rep_end;
			end
			PH_EMPTY: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase

		// The next command is taken as the last word of the current one goes out.
		q_pop   = q_avail && ((phase_q == PH_IDLE) || (emit_en && done));
		phase_d = phase_q;
		idx_d   = idx_q;
		if (q_pop) begin
			phase_d = first_phase(q_cmd, repl.len);
			idx_d   = '0;
		end else if (emit_en) begin
			if (done) begin
				phase_d = PH_IDLE;
				idx_d   = '0;
			end else begin
				phase_d = step_phase;
				idx_d   = step_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_en) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_unit_q  <= res_unit;
			out_valid_q <= res_real;
			out_last_q  <= cur_q.last && done;
		end
	end

	assign result_valid = result_valid_q;
	assign out_unit     = out_unit_q;
	assign out_valid    = out_valid_q;
	assign out_last     = out_last_q;

	`LFR_ASSERT(a_rep_idx, (emit_en && (phase_q == PH_REP1 || phase_q == PH_REP2)) |-> ({1'b0, idx_q} < repl.len), "replacement index past its length")
	`LFR_ASSERT(a_unit_idx, (emit_en && phase_q == PH_UNITS) |-> ({1'b0, idx_q} < cur_q.n_units), "unit index past the command's run")
	`LFR_ASSERT(a_empty_last, (phase_q == PH_EMPTY) |-> cur_q.last, "empty marker outside a string end")
	`LFR_ASSERT_NEXT(a_drain_idle, emit_en && done && !q_avail, phase_q == PH_IDLE, "sequencer busy after its last word")

endmodule

`default_nettype wire

// File: rtl/literal_find_and_replace.sv
// An accepted word's command is written to the queue, loaded into the back end's
// command register and walked into the output register. Throughput: one input word
// per cycle while each word yields at most one result and no stall holds the output;
// the back-end sequencer walks a command one result word at a time.
// Reset clears the configuration, the window count, the queue and the output valid;
// no clearing pass is needed and the block accepts words straight after reset.
// ----------------------------------------------------------------------------
// literal_find_and_replace
// Streaming literal search and replace over 16-bit code units: front end,
// command queue and back-end output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_find_and_replace (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [lfr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [lfr_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [lfr_pkg::UNIT_W-1:0]  src_unit,
	input  wire logic                        unit_valid,
	input  wire logic                        end_of_string,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [lfr_pkg::UNIT_W-1:0]       out_unit,
	output logic                             out_valid,
	output logic                             out_last
);
	import lfr_pkg::*;

	lfr_cmd_t  push_cmd;
	lfr_cmd_t  head_cmd;
	lfr_repl_t repl;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_avail;

	assign item_stall = q_full;

	lfr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.src_unit      (src_unit),
		.unit_valid    (unit_valid),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (push_cmd),
		.repl          (repl)
	);

	lfr_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.avail    (q_avail)
	);

	lfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_cmd        (head_cmd),
		.q_avail      (q_avail),
		.repl         (repl),
		.result_stall (result_stall),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.out_unit     (out_unit),
		.out_valid    (out_valid),
		.out_last     (out_last)
	);

endmodule

`default_nettype wire
